// ----- design/arif_pkg.sv -----
// Shared types and constants for the acoustic Riemann interface flux block.
`default_nettype none

package arif_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIV_STEPS         = 32;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_IMPED = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;

   typedef struct packed {
      logic zero;
      logic neg_v;
      logic neg_p;
      logic ovf_v;
      logic ovf_p;
   } flags_type;

endpackage

`default_nettype wire

// ----- design/acoustic_riemann_interface_flux.sv -----
// Top level: acoustic Riemann solver interface velocity and pressure.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  vel, pres, imped left and right
//  rsp      out        rsp_valid/rsp_stall  star_velocity, star_pressure, status
//
// One item per cycle while the skid register is empty; 5 arithmetic stages, 32 divider
// stages and an output register. The 32-stage restoring divider is the deepest part.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A skid register behind the output register absorbs one item; req_stall is
// that skid register's occupancy, and the whole pipeline holds while it is full.
`default_nettype none

module acoustic_riemann_interface_flux #(
   parameter int FRAC_BITS = arif_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_vel_left,
   input  wire logic signed [31:0] req_vel_right,
   input  wire logic signed [31:0] req_pres_left,
   input  wire logic signed [31:0] req_pres_right,
   input  wire logic [30:0]        req_imped_left,
   input  wire logic [30:0]        req_imped_right,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_star_velocity,
   output logic signed [31:0]      rsp_star_pressure,
   output logic [1:0]              rsp_status
);

   localparam int NV_W = ((33 + FRAC_BITS > 64) ? 33 + FRAC_BITS : 64) + 2;
   localparam int NP_W = ((65 + FRAC_BITS > 96) ? 65 + FRAC_BITS : 96) + 2;

   logic pipe_en;

   // stage 1
   logic               v1_ff;
   logic signed [63:0] mvr1_ff, mvl1_ff, mpr1_ff, mpl1_ff;
   logic signed [63:0] mvr1_in, mvl1_in, mpr1_in, mpl1_in;
   logic [61:0]        zz1_ff, zz1_in;
   logic signed [32:0] dv1_ff, dv1_in, dp1_ff, dp1_in;
   logic [31:0]        den1_ff, den1_in;

   // stage 2
   logic                   v2_ff;
   logic signed [NV_W-1:0] nv2_ff, nv2_in;
   logic signed [64:0]     ps2_ff, ps2_in, plo2_ff, plo2_in, phi2_ff, phi2_in;
   logic [31:0]            den2_ff;

   // stage 3
   logic                   v3_ff;
   logic signed [NV_W-1:0] nv3_ff;
   logic signed [NP_W-1:0] np3_ff, np3_in;
   logic [31:0]            den3_ff;

   // stage 4
   logic            v4_ff;
   logic            negv4_ff, negp4_ff;
   logic [NV_W-1:0] magv4_ff, magv4_in;
   logic [NP_W-1:0] magp4_ff, magp4_in, absp4;
   logic [31:0]     den4_ff;

   // stage 5
   logic                v5_ff;
   arif_pkg::flags_type flags5_ff, flags5_in;
   logic [31:0]         den5_ff;
   logic [31:0]         remv5_ff, remv5_in, nqv5_ff, remp5_ff, remp5_in, nqp5_ff;

   // divider output
   logic                dv_valid;
   arif_pkg::flags_type dv_flags;
   logic [31:0]         dv_qv, dv_qp;

   // result
   logic signed [31:0] res_vel, res_pres;
   logic [1:0]         res_status;
   logic               sat_v, sat_p;

   logic               out_valid_ff, skid_valid_ff;
   logic signed [31:0] out_vel_ff, out_pres_ff, skid_vel_ff, skid_pres_ff;
   logic [1:0]         out_status_ff, skid_status_ff;
   logic               out_take;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: products, differences and impedance sum
   always_comb begin
      mvr1_in = $signed({1'b0, req_imped_right}) * req_vel_right;
      mvl1_in = $signed({1'b0, req_imped_left}) * req_vel_left;
      mpr1_in = $signed({1'b0, req_imped_right}) * req_pres_left;
      mpl1_in = $signed({1'b0, req_imped_left}) * req_pres_right;
      zz1_in  = 62'(req_imped_left) * 62'(req_imped_right);
      dv1_in  = 33'(req_vel_left) - 33'(req_vel_right);
      dp1_in  = 33'(req_pres_left) - 33'(req_pres_right);
      den1_in = 32'(req_imped_left) + 32'(req_imped_right);
   end

   // stage 2: velocity numerator, pressure product sum, split zL*zR*dv
   always_comb begin
      nv2_in  = (NV_W'(dp1_ff) <<< FRAC_BITS) + NV_W'(mvr1_ff) + NV_W'(mvl1_ff);
      ps2_in  = 65'(mpr1_ff) + 65'(mpl1_ff);
      plo2_in = $signed({1'b0, zz1_ff[30:0]}) * dv1_ff;
      phi2_in = $signed({1'b0, zz1_ff[61:31]}) * dv1_ff;
   end

   // stage 3: pressure numerator
   assign np3_in = (NP_W'(ps2_ff) <<< FRAC_BITS) + (NP_W'(phi2_ff) <<< 31) + NP_W'(plo2_ff);

   // stage 4: magnitudes
   always_comb begin
      magv4_in = nv3_ff[NV_W-1] ? NV_W'(-nv3_ff) : NV_W'(nv3_ff);
      absp4    = np3_ff[NP_W-1] ? NP_W'(-np3_ff) : NP_W'(np3_ff);
      magp4_in = absp4 >> FRAC_BITS;
   end

   // stage 5: overflow check and divider seed
   always_comb begin
      flags5_in.zero  = (den4_ff == 32'd0);
      flags5_in.neg_v = negv4_ff;
      flags5_in.neg_p = negp4_ff;
      flags5_in.ovf_v = magv4_ff[NV_W-1:32] >= (NV_W-32)'(den4_ff);
      flags5_in.ovf_p = magp4_ff[NP_W-1:32] >= (NP_W-32)'(den4_ff);
      remv5_in = flags5_in.ovf_v ? 32'd0 : magv4_ff[63:32];
      remp5_in = flags5_in.ovf_p ? 32'd0 : magp4_ff[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mvr1_ff   <= mvr1_in;
         mvl1_ff   <= mvl1_in;
         mpr1_ff   <= mpr1_in;
         mpl1_ff   <= mpl1_in;
         zz1_ff    <= zz1_in;
         dv1_ff    <= dv1_in;
         dp1_ff    <= dp1_in;
         den1_ff   <= den1_in;
         nv2_ff    <= nv2_in;
         ps2_ff    <= ps2_in;
         plo2_ff   <= plo2_in;
         phi2_ff   <= phi2_in;
         den2_ff   <= den1_ff;
         nv3_ff    <= nv2_ff;
         np3_ff    <= np3_in;
         den3_ff   <= den2_ff;
         negv4_ff  <= nv3_ff[NV_W-1];
         negp4_ff  <= np3_ff[NP_W-1];
         magv4_ff  <= magv4_in;
         magp4_ff  <= magp4_in;
         den4_ff   <= den3_ff;
         flags5_ff <= flags5_in;
         den5_ff   <= den4_ff;
         remv5_ff  <= remv5_in;
         nqv5_ff   <= magv4_ff[31:0];
         remp5_ff  <= remp5_in;
         nqp5_ff   <= magp4_ff[31:0];
      end
   end

   arif_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v5_ff),
      .in_flags  (flags5_ff),
      .in_den    (den5_ff),
      .in_rem_v  (remv5_ff),
      .in_nq_v   (nqv5_ff),
      .in_rem_p  (remp5_ff),
      .in_nq_p   (nqp5_ff),
      .out_valid (dv_valid),
      .out_flags (dv_flags),
      .out_q_v   (dv_qv),
      .out_q_p   (dv_qp)
   );

   // sign, saturation and zero-impedance status
   always_comb begin
      sat_v = dv_flags.ovf_v || (dv_flags.neg_v ? (dv_qv > 32'h8000_0000) : dv_qv[31]);
      sat_p = dv_flags.ovf_p || (dv_flags.neg_p ? (dv_qp > 32'h8000_0000) : dv_qp[31]);
      if (dv_flags.zero) begin
         res_vel    = 32'sd0;
         res_pres   = 32'sd0;
         res_status = arif_pkg::STATUS_ZERO_IMPED;
      end else begin
         if (sat_v) begin
            res_vel = dv_flags.neg_v ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            res_vel = dv_flags.neg_v ? $signed(32'd0 - dv_qv) : $signed(dv_qv);
         end
         if (sat_p) begin
            res_pres = dv_flags.neg_p ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            res_pres = dv_flags.neg_p ? $signed(32'd0 - dv_qp) : $signed(dv_qp);
         end
         res_status = (sat_v || sat_p) ? arif_pkg::STATUS_SATURATED : arif_pkg::STATUS_OK;
      end
   end

   assign out_take = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= dv_valid;
         end
      end else if (pipe_en && dv_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_vel_ff    <= skid_vel_ff;
            out_pres_ff   <= skid_pres_ff;
            out_status_ff <= skid_status_ff;
         end else begin
            out_vel_ff    <= res_vel;
            out_pres_ff   <= res_pres;
            out_status_ff <= res_status;
         end
      end else if (pipe_en) begin
         skid_vel_ff    <= res_vel;
         skid_pres_ff   <= res_pres;
         skid_status_ff <= res_status;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_star_velocity = out_vel_ff;
   assign rsp_star_pressure = out_pres_ff;
   assign rsp_status        = out_status_ff;

endmodule

`default_nettype wire

// ----- design/arif_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
`default_nettype none

module arif_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire arif_pkg::flags_type in_flags,
   input  wire logic [31:0]         in_den,
   input  wire logic [31:0]         in_rem_v,
   input  wire logic [31:0]         in_nq_v,
   input  wire logic [31:0]         in_rem_p,
   input  wire logic [31:0]         in_nq_p,
   output logic                     out_valid,
   output arif_pkg::flags_type      out_flags,
   output logic [31:0]              out_q_v,
   output logic [31:0]              out_q_p
);

   localparam int STEPS = arif_pkg::DIV_STEPS;

   logic                valid_ff [0:STEPS-1];
   arif_pkg::flags_type flags_ff [0:STEPS-1];
   logic [31:0]         den_ff   [0:STEPS-2];
   logic [31:0]         remv_ff  [0:STEPS-1];
   logic [31:0]         nqv_ff   [0:STEPS-1];
   logic [31:0]         remp_ff  [0:STEPS-1];
   logic [31:0]         nqp_ff   [0:STEPS-1];

   logic                valid_in [0:STEPS-1];
   arif_pkg::flags_type flags_in [0:STEPS-1];
   logic [31:0]         den_in   [0:STEPS-2];
   logic [31:0]         remv_in  [0:STEPS-1];
   logic [31:0]         nqv_in   [0:STEPS-1];
   logic [31:0]         remp_in  [0:STEPS-1];
   logic [31:0]         nqp_in   [0:STEPS-1];

   // one restoring step: returns {remainder, shifted numerator/quotient}
   function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] nq,
                                            input logic [31:0] den);
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;
      t    = {rem, nq[31]};
      diff = t - {1'b0, den};
      ge   = (t >= {1'b0, den});
      return {(ge ? diff[31:0] : t[31:0]), {nq[30:0], ge}};
   endfunction

   always_comb begin
      logic [31:0] d;
      logic [63:0] sv;
      logic [63:0] sp;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            d           = in_den;
            valid_in[k] = in_valid;
            flags_in[k] = in_flags;
            sv          = div_step(in_rem_v, in_nq_v, in_den);
            sp          = div_step(in_rem_p, in_nq_p, in_den);
         end else begin
            d           = den_ff[k-1];
            valid_in[k] = valid_ff[k-1];
            flags_in[k] = flags_ff[k-1];
            sv          = div_step(remv_ff[k-1], nqv_ff[k-1], den_ff[k-1]);
            sp          = div_step(remp_ff[k-1], nqp_ff[k-1], den_ff[k-1]);
         end
         if (k < STEPS-1) begin
            den_in[k] = d;
         end
         remv_in[k] = sv[63:32];
         nqv_in[k]  = sv[31:0];
         remp_in[k] = sp[63:32];
         nqp_in[k]  = sp[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            flags_ff[k] <= flags_in[k];
            remv_ff[k]  <= remv_in[k];
            nqv_ff[k]   <= nqv_in[k];
            remp_ff[k]  <= remp_in[k];
            nqp_ff[k]   <= nqp_in[k];
         end
         for (int k = 0; k < STEPS-1; k++) begin
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_flags = flags_ff[STEPS-1];
   assign out_q_v   = nqv_ff[STEPS-1];
   assign out_q_p   = nqp_ff[STEPS-1];

endmodule

`default_nettype wire

// ----- design/arif_checker.sv -----
// Port-level checks for the acoustic Riemann interface flux block, with bind.
`default_nettype none

module arif_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_star_velocity,
   input wire logic signed [31:0] rsp_star_pressure,
   input wire logic [1:0]         rsp_status
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output or stall not cleared by reset");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == arif_pkg::STATUS_OK ||
                     rsp_status == arif_pkg::STATUS_ZERO_IMPED ||
                     rsp_status == arif_pkg::STATUS_SATURATED))
      else $error("undefined status code");

   a_zero_imped : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == arif_pkg::STATUS_ZERO_IMPED) |->
         (rsp_star_velocity == 32'sd0 && rsp_star_pressure == 32'sd0))
      else $error("zero impedance item with nonzero result");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == arif_pkg::STATUS_SATURATED) |->
         (rsp_star_velocity == 32'sh7FFF_FFFF || rsp_star_velocity == 32'sh8000_0000 ||
          rsp_star_pressure == 32'sh7FFF_FFFF || rsp_star_pressure == 32'sh8000_0000))
      else $error("saturated status without a limit value");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_star_velocity) && $stable(rsp_star_pressure) &&
          $stable(rsp_status)))
      else $error("stalled item changed");

endmodule

bind acoustic_riemann_interface_flux arif_checker u_arif_checker (.*);

`default_nettype wire
